// ===== rtl/core/pthp_pkg.sv =====
// ----------------------------------------------------------------------------
// Parenthesized tree parser package
// Character codes and field widths shared by the parser RTL.
// ----------------------------------------------------------------------------
package pthp_pkg;

	localparam int CHAR_W      = 8;
	localparam int LETTER_W    = 7;
	localparam int TREE_SIZE_W = 12;

	localparam logic [TREE_SIZE_W-1:0] TREE_SIZE_RESET = 12'd2048;

	localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

endpackage

// ===== rtl/core/paren_tree_to_heap_parser_top.sv =====
// ----------------------------------------------------------------------------
// Parenthesized tree to heap position parser
// Takes one byte of tree text per request and reports the heap slot of
// every upper-case letter until a slot reaches the size, which gives an error.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle, and its result appears on the
// output in the cycle after the byte is taken. The parent stack lives in a
// synchronous memory whose registered read always holds the current top of
// stack; a push is forwarded into that read register, so pushes, pops and
// lookups follow each other in back-to-back cycles. The input stalls only
// while a result waits in the output register and the output is stalled.
module paren_tree_to_heap_parser_top
	import pthp_pkg::*;
#(
	parameter int HEAP_SLOTS    = 2048,
	parameter int STACK_ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic [TREE_SIZE_W-1:0]      cfg_wdata,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [CHAR_W-1:0]           char_code,
	input  logic                        start_of_string,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [$clog2(HEAP_SLOTS)-1:0] node_index,
	output logic [LETTER_W-1:0]         node_letter,
	output logic                        overflow_error
);

	localparam int IDX_W  = $clog2(HEAP_SLOTS);
	localparam int SLOT_W = IDX_W + 1;
	localparam int CMP_W  = (SLOT_W > TREE_SIZE_W) ? SLOT_W : TREE_SIZE_W;
	localparam int SP_W   = $clog2(STACK_ENTRIES);
	localparam int CNT_W  = $clog2(STACK_ENTRIES + 1);

	logic [TREE_SIZE_W-1:0] tree_size_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       last_q;
	logic                   right_q;
	logic                   stop_q;
	logic [IDX_W-1:0]       top_q;

	logic [IDX_W-1:0]       stack_mem [STACK_ENTRIES];

	logic                   out_valid_q;
	logic [IDX_W-1:0]       node_index_q;
	logic [LETTER_W-1:0]    node_letter_q;
	logic                   overflow_error_q;

	logic                   acc;
	logic                   is_letter;
	logic [CNT_W-1:0]       count_eff;
	logic [IDX_W-1:0]       last_eff;
	logic                   right_eff;
	logic                   stop_eff;
	logic [CNT_W-1:0]       count_d;
	logic [IDX_W-1:0]       last_d;
	logic                   right_d;
	logic                   stop_d;
	logic                   push_en;
	logic                   push_wr;
	logic [SP_W-1:0]        waddr;
	logic [CNT_W-1:0]       count_n;
	logic [SP_W-1:0]        raddr;
	logic [SLOT_W-1:0]      slot;
	logic [CMP_W-1:0]       limit;
	logic                   res_valid;
	logic                   res_err;
	logic [IDX_W-1:0]       res_index;
	logic [LETTER_W-1:0]    res_letter;

	assign in_stall       = out_valid_q & out_stall;
	assign acc            = in_valid & ~in_stall;
	assign out_valid      = out_valid_q;
	assign node_index     = node_index_q;
	assign node_letter    = node_letter_q;
	assign overflow_error = overflow_error_q;

	assign limit = (CMP_W'(tree_size_q) < CMP_W'(HEAP_SLOTS)) ?
		CMP_W'(tree_size_q) : CMP_W'(HEAP_SLOTS);

	always_comb begin
		is_letter  = char_code inside {[CHAR_A:CHAR_Z]};
		count_eff  = start_of_string ? '0 : count_q;
		last_eff   = start_of_string ? '0 : last_q;
		right_eff  = start_of_string ? 1'b0 : right_q;
		stop_eff   = start_of_string ? 1'b0 : stop_q;
		slot       = (count_eff == '0) ? SLOT_W'(1) : {top_q, right_eff};
		count_d    = count_eff;
		last_d     = last_eff;
		right_d    = right_eff;
		stop_d     = stop_eff;
		push_en    = 1'b0;
		res_valid  = 1'b0;
		res_err    = 1'b0;
		res_index  = '0;
		res_letter = '0;
		if (!stop_eff) begin
			if (char_code == CHAR_OPEN) begin
				if (last_eff != '0) begin
					if (count_eff < CNT_W'(STACK_ENTRIES)) begin
						push_en = 1'b1;
						count_d = count_eff + CNT_W'(1);
					end
					right_d = 1'b0;
				end
				last_d = '0;
			end else if (char_code == CHAR_CLOSE) begin
				if (count_eff != '0) begin
					count_d = count_eff - CNT_W'(1);
				end
				last_d = '0;
			end else if (is_letter) begin
				res_valid = 1'b1;
				if (CMP_W'(slot) >= limit) begin
					res_err = 1'b1;
					stop_d  = 1'b1;
				end else begin
					res_index  = slot[IDX_W-1:0];
					res_letter = char_code[LETTER_W-1:0];
					last_d     = slot[IDX_W-1:0];
					right_d    = 1'b1;
				end
			end
		end
	end

	assign push_wr = acc & push_en;
	assign waddr   = SP_W'(count_eff);
	assign count_n = acc ? count_d : count_q;
	assign raddr   = (count_n == '0) ? '0 : SP_W'(count_n - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (push_wr) begin
			stack_mem[waddr] <= last_eff;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= push_wr ? last_eff : stack_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_size_q <= TREE_SIZE_RESET;
			count_q     <= '0;
			last_q      <= '0;
			right_q     <= 1'b0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tree_size_q <= cfg_wdata;
			end
			if (acc) begin
				count_q <= count_d;
				last_q  <= last_d;
				right_q <= right_d;
				stop_q  <= stop_d;
			end
			if (acc && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && res_valid) begin
			node_index_q     <= res_index;
			node_letter_q    <= res_letter;
			overflow_error_q <= res_err;
		end
	end

`ifndef SYNTHESIS
	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res_valid && res_err) |=> stop_q)
		else $error("Error result did not stop parsing.");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && stop_q && !start_of_string) |=> ($stable(count_q) && $stable(last_q)))
		else $error("Stopped parser changed its state.");

	a_push_forward: assert property (@(posedge clk) disable iff (!arst_n)
		push_wr |=> (count_q == $past(count_eff) + CNT_W'(1) && top_q == $past(last_eff)))
		else $error("Push did not update the top of stack.");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overflow_error_q) |-> (node_index_q == '0 && node_letter_q == '0))
		else $error("Error result carries nonzero fields.");
`endif

endmodule
